>>> hdl/kstk_pkg.sv
// Shared constants, codes and result-word layout for the shared-store stack block.
// No dependencies; every other file refers to this package by scoped names.

package kstk_pkg;

  // Sizes
  localparam int STACK_COUNT = 4;
  localparam int SLOT_COUNT  = 16;

  localparam int STK_IDX_W  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  // Link values 0..SLOT_COUNT-1 name a slot, SLOT_COUNT is the null link
  localparam int LINK_W     = $clog2(SLOT_COUNT + 1);

  // Field widths
  localparam int CMD_W    = 1;
  localparam int SID_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOT_COUNT);

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
  localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd2;

  // Value returned by a refused pop (-1)
  localparam logic [DATA_W-1:0] FAIL_VALUE = '1;

  // Stream widths
  localparam int S_TUSER_W = CMD_W + SID_W;
  localparam int M_TUSER_W = STATUS_W + 2;

endpackage

>>> hdl/k_stacks_shared_store_top.sv
// Top level of the shared-store stack block: request register, one-pass update of
// the free list and stack heads, result register. Depends on kstk_pkg.
//
//  channel  | role   | tdata            | tuser
//  ---------+--------+------------------+----------------------------------------
//  s_*      | in     | value[31:0]      | cmd[0], stack_id[2:1]
//  m_*      | out    | pop_value[31:0]  | status[1:0], store_full[2], stack_empty[3]
//
// One request per cycle sustained while the output is not stalled.
// Each request reads one link entry (a pop also one data entry); a success writes
// the link entry (a push also the data) between request and result register.
// rst (synchronous, active high) empties all stacks and rebuilds the free list
// 0 -> 1 -> ... -> last slot; the data store is not cleared.
// A stalled result holds the result register and the request register; the input
// takes a new request whenever the request register is empty or moving on.

module k_stacks_shared_store_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [kstk_pkg::DATA_W-1:0]     s_tdata,   // value
  input  logic [kstk_pkg::S_TUSER_W-1:0]  s_tuser,   // cmd, stack_id
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kstk_pkg::DATA_W-1:0]     m_tdata,   // pop_value
  output logic [kstk_pkg::M_TUSER_W-1:0]  m_tuser    // status, store_full, stack_empty
);

  // Request register
  logic                             req_valid;
  logic [kstk_pkg::CMD_W-1:0]       req_cmd;
  logic [kstk_pkg::SID_W-1:0]       req_sid;
  logic [kstk_pkg::DATA_W-1:0]      req_value;

  // Stores
  logic [kstk_pkg::DATA_W-1:0]  slot_data [kstk_pkg::SLOT_COUNT];
  logic [kstk_pkg::LINK_W-1:0]  slot_link [kstk_pkg::SLOT_COUNT];
  logic [kstk_pkg::LINK_W-1:0]  stack_top [kstk_pkg::STACK_COUNT];
  logic [kstk_pkg::LINK_W-1:0]  free_head;

  // Step logic
  logic                             advance;
  logic                             step;
  logic                             is_push;
  logic                             sid_ok;
  logic [kstk_pkg::STK_IDX_W-1:0]   sid_idx;
  logic [kstk_pkg::LINK_W-1:0]      top_cur;
  logic                             free_ok;
  logic                             top_ok;
  logic                             op_ok;
  logic [kstk_pkg::LINK_W-1:0]      slot;
  logic [kstk_pkg::SLOT_IDX_W-1:0]  slot_idx;
  logic [kstk_pkg::LINK_W-1:0]      link_rd;
  logic [kstk_pkg::LINK_W-1:0]      free_head_next;
  logic [kstk_pkg::LINK_W-1:0]      top_next;
  logic [kstk_pkg::DATA_W-1:0]      pop_value_next;
  logic [kstk_pkg::STATUS_W-1:0]    status_next;

  // Handshake: the result register frees up when empty or taken
  assign advance  = !m_tvalid || m_tready;
  assign step     = req_valid && advance;
  assign s_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      req_cmd   <= s_tuser[kstk_pkg::CMD_W-1:0];
      req_sid   <= s_tuser[kstk_pkg::S_TUSER_W-1:kstk_pkg::CMD_W];
      req_value <= s_tdata;
    end
  end

  // Decode the request and pick the slot it works on
  always_comb begin
    is_push  = (req_cmd == kstk_pkg::CMD_PUSH);
    sid_ok   = (32'(req_sid) < 32'(kstk_pkg::STACK_COUNT));
    sid_idx  = kstk_pkg::STK_IDX_W'(req_sid);
    top_cur  = stack_top[sid_idx];
    free_ok  = (32'(free_head) < 32'(kstk_pkg::SLOT_COUNT));
    top_ok   = (32'(top_cur) < 32'(kstk_pkg::SLOT_COUNT));
    op_ok    = sid_ok && (is_push ? free_ok : top_ok);
    slot     = is_push ? free_head : top_cur;
    slot_idx = kstk_pkg::SLOT_IDX_W'(slot);
    link_rd  = slot_link[slot_idx];
  end

  // Next heads and result fields
  always_comb begin
    free_head_next = free_head;
    top_next       = top_cur;
    pop_value_next = '0;
    status_next    = kstk_pkg::ST_OK;
    if (is_push) begin
      if (op_ok) begin
        free_head_next = link_rd;
        top_next       = slot;
      end else begin
        status_next = kstk_pkg::ST_PUSH_FULL;
      end
    end else begin
      if (op_ok) begin
        free_head_next = slot;
        top_next       = link_rd;
        pop_value_next = slot_data[slot_idx];
      end else begin
        status_next    = kstk_pkg::ST_POP_EMPTY;
        pop_value_next = kstk_pkg::FAIL_VALUE;
      end
    end
  end

  // Link store and heads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kstk_pkg::SLOT_COUNT; i++) begin
        slot_link[i] <= kstk_pkg::LINK_W'(i + 1);
      end
      for (int j = 0; j < kstk_pkg::STACK_COUNT; j++) begin
        stack_top[j] <= kstk_pkg::NULL_LINK;
      end
      free_head <= '0;
    end else if (step && op_ok) begin
      slot_link[slot_idx] <= is_push ? top_cur : free_head;
      stack_top[sid_idx]  <= top_next;
      free_head           <= free_head_next;
    end
  end

  // Data store, written by a successful push
  always_ff @(posedge clk) begin
    if (step && op_ok && is_push) begin
      slot_data[slot_idx] <= req_value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= pop_value_next;
      m_tuser <= {!sid_ok || !(32'(top_next) < 32'(kstk_pkg::SLOT_COUNT)),
                  !(32'(free_head_next) < 32'(kstk_pkg::SLOT_COUNT)),
                  status_next};
    end
  end

endmodule

>>> hdl/kstk_checker.sv
// Port-level checks for the shared-store stack block, bound to its top level.
// Depends on kstk_pkg and k_stacks_shared_store_top.

module kstk_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [kstk_pkg::DATA_W-1:0]     m_tdata,
  input logic [kstk_pkg::M_TUSER_W-1:0]  m_tuser
);

  // A stalled result holds still
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A refused pop returns -1 and reports the stack as empty
  a_pop_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[kstk_pkg::STATUS_W-1:0] == kstk_pkg::ST_POP_EMPTY
      |-> m_tdata == kstk_pkg::FAIL_VALUE && m_tuser[kstk_pkg::STATUS_W+1])
    else $error("refused pop with wrong value or flags");

  // A refused push returns zero
  a_push_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[kstk_pkg::STATUS_W-1:0] == kstk_pkg::ST_PUSH_FULL
      |-> m_tdata == '0)
    else $error("refused push with nonzero value");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind k_stacks_shared_store_top kstk_checker u_kstk_checker (.*);

>>> tb/k_stacks_shared_store_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for k_stacks_shared_store_top: push/pop requests go in on the
// s_* stream, results are checked against an in-bench model of the shared store.
// Depends on kstk_pkg and the top module only.

module k_stacks_shared_store_top_test;

  typedef struct {
    logic [kstk_pkg::CMD_W-1:0]  cmd;
    logic [kstk_pkg::SID_W-1:0]  stack_id;
    logic [kstk_pkg::DATA_W-1:0] value;
  } stack_req_t;

  typedef struct {
    logic [kstk_pkg::DATA_W-1:0]   pop_value;
    logic [kstk_pkg::STATUS_W-1:0] status;
    logic                          store_full;
    logic                          stack_empty;
  } stack_res_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [kstk_pkg::DATA_W-1:0]      s_tdata = '0;    // value
  logic [kstk_pkg::S_TUSER_W-1:0]   s_tuser = '0;    // cmd[0], stack_id[2:1]
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [kstk_pkg::DATA_W-1:0]      m_tdata;         // pop_value
  logic [kstk_pkg::M_TUSER_W-1:0]   m_tuser;  // status[1:0], store_full[2], stack_empty[3]

  k_stacks_shared_store_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the shared store: slot data, slot links, stack heads, free-list head
  logic [kstk_pkg::DATA_W-1:0] slot_val  [kstk_pkg::SLOT_COUNT];
  logic [kstk_pkg::LINK_W-1:0] slot_next [kstk_pkg::SLOT_COUNT];
  logic [kstk_pkg::LINK_W-1:0] top_of    [kstk_pkg::STACK_COUNT];
  logic [kstk_pkg::LINK_W-1:0] free_ptr;

  stack_req_t request_queue[$];
  stack_res_t due_results[$];

  int queued_count   = 0;
  int results_seen   = 0;
  int errors         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit req_taken      = 1'b0;

  function automatic void reset_store_model();
    for (int i = 0; i < kstk_pkg::SLOT_COUNT; i++) begin
      slot_val[i]  = '0;
      slot_next[i] = kstk_pkg::LINK_W'(i + 1);   // last slot ends up on the null link
    end
    for (int i = 0; i < kstk_pkg::STACK_COUNT; i++) top_of[i] = kstk_pkg::NULL_LINK;
    free_ptr = '0;
  endfunction

  // Apply one request to the model and return the result it should produce
  function automatic stack_res_t apply_stack_op(stack_req_t r);
    stack_res_t                      res;
    logic [kstk_pkg::SLOT_IDX_W-1:0] slot;
    res.pop_value = '0;
    res.status    = kstk_pkg::ST_OK;
    if (r.cmd == kstk_pkg::CMD_PUSH) begin
      if (free_ptr == kstk_pkg::NULL_LINK) begin
        res.status = kstk_pkg::ST_PUSH_FULL;
      end else begin
        slot               = kstk_pkg::SLOT_IDX_W'(free_ptr);
        free_ptr           = slot_next[slot];
        slot_next[slot]    = top_of[r.stack_id];
        top_of[r.stack_id] = kstk_pkg::LINK_W'(slot);
        slot_val[slot]     = r.value;
      end
    end else begin
      if (top_of[r.stack_id] == kstk_pkg::NULL_LINK) begin
        res.status    = kstk_pkg::ST_POP_EMPTY;
        res.pop_value = kstk_pkg::FAIL_VALUE;
      end else begin
        slot               = kstk_pkg::SLOT_IDX_W'(top_of[r.stack_id]);
        res.pop_value      = slot_val[slot];
        top_of[r.stack_id] = slot_next[slot];
        slot_next[slot]    = free_ptr;
        free_ptr           = kstk_pkg::LINK_W'(slot);
      end
    end
    res.store_full  = (free_ptr == kstk_pkg::NULL_LINK);
    res.stack_empty = (top_of[r.stack_id] == kstk_pkg::NULL_LINK);
    return res;
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Request driver: changes inputs on the falling edge
  always @(negedge clk) begin
    stack_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (request_queue.size() > 0 && !roll(send_idle_pct)) begin
        r = request_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= r.value;
        s_tuser  <= {r.stack_id, r.cmd};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !roll(recv_stall_pct);
  end

  // Monitor: check accepted results, then predict from accepted requests
  always @(posedge clk) begin
    stack_req_t r;
    stack_res_t want;
    req_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result pop_value=%h tuser=%h", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (m_tdata !== want.pop_value) begin
            $display("%0t: pop_value expected %h actual %h", $time, want.pop_value, m_tdata);
            errors++;
          end
          if (m_tuser[1:0] !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser[1:0]);
            errors++;
          end
          if (m_tuser[2] !== want.store_full) begin
            $display("%0t: store_full expected %b actual %b", $time, want.store_full,
                     m_tuser[2]);
            errors++;
          end
          if (m_tuser[3] !== want.stack_empty) begin
            $display("%0t: stack_empty expected %b actual %b", $time, want.stack_empty,
                     m_tuser[3]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req_taken = 1'b1;
        r.cmd      = s_tuser[0];
        r.stack_id = s_tuser[2:1];
        r.value    = s_tdata;
        due_results.push_back(apply_stack_op(r));
      end
    end
  end

  task automatic queue_req(logic [kstk_pkg::CMD_W-1:0] cmd, logic [kstk_pkg::SID_W-1:0] sid,
                           logic [kstk_pkg::DATA_W-1:0] value);
    stack_req_t r;
    r.cmd      = cmd;
    r.stack_id = sid;
    r.value    = value;
    request_queue.push_back(r);
    queued_count++;
  endtask

  // Mostly random words, now and then a corner value
  function automatic logic [kstk_pkg::DATA_W-1:0] pick_value();
    logic [kstk_pkg::DATA_W-1:0] corners [4];
    corners[0] = '0;
    corners[1] = '1;
    corners[2] = {1'b1, {(kstk_pkg::DATA_W-1){1'b0}}};
    corners[3] = {1'b0, {(kstk_pkg::DATA_W-1){1'b1}}};
    if ($urandom_range(0, 7) == 0) return corners[2'($urandom_range(0, 3))];
    return $urandom;
  endfunction

  // Bursts that lean towards push or pop, so the store swings between full and empty
  task automatic queue_random(int count);
    int left;
    int burst;
    int push_pct;
    bit lean_push;
    left      = count;
    lean_push = 1'b1;
    while (left > 0) begin
      burst    = $urandom_range(4, 24);
      push_pct = lean_push ? 85 : 15;
      for (int i = 0; i < burst && left > 0; i++) begin
        queue_req(roll(push_pct) ? kstk_pkg::CMD_PUSH : kstk_pkg::CMD_POP,
                  kstk_pkg::SID_W'($urandom_range(0, 3)), pick_value());
        left--;
      end
      lean_push = !lean_push;
    end
  endtask

  task automatic wait_drained();
    while (results_seen < queued_count) @(posedge clk);
  endtask

  initial begin
    reset_store_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: pops on empty stacks, fill the store with corner and random values,
    // a push on a full store, then pops on stacks 0, 1 and 3 with a push in between
    queue_req(kstk_pkg::CMD_POP, 2'd0, 32'h1234_5678);
    queue_req(kstk_pkg::CMD_POP, 2'd3, '0);
    queue_req(kstk_pkg::CMD_PUSH, 2'd0, 32'h7FFF_FFFF);
    queue_req(kstk_pkg::CMD_PUSH, 2'd0, 32'h8000_0000);
    queue_req(kstk_pkg::CMD_PUSH, 2'd1, 32'h0000_0000);
    queue_req(kstk_pkg::CMD_PUSH, 2'd1, 32'hFFFF_FFFF);
    queue_req(kstk_pkg::CMD_PUSH, 2'd2, 32'hAAAA_AAAA);
    queue_req(kstk_pkg::CMD_PUSH, 2'd3, 32'h5555_5555);
    for (int i = 0; i < kstk_pkg::SLOT_COUNT - 6; i++)
      queue_req(kstk_pkg::CMD_PUSH, kstk_pkg::SID_W'(i % kstk_pkg::STACK_COUNT), $urandom);
    queue_req(kstk_pkg::CMD_PUSH, 2'd2, 32'hDEAD_BEEF);
    queue_req(kstk_pkg::CMD_POP, 2'd0, '0);
    queue_req(kstk_pkg::CMD_POP, 2'd1, '1);
    queue_req(kstk_pkg::CMD_PUSH, 2'd1, 32'h0F0F_0F0F);
    queue_req(kstk_pkg::CMD_POP, 2'd3, '0);
    wait_drained();

    // Random traffic under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      queue_random(250);
      wait_drained();
    end

    // Allow for any late extra result
    repeat (10) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("k_stacks_shared_store_top verification clean");
    end else begin
      $display("k_stacks_shared_store_top verification failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("k_stacks_shared_store_top verification failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/kstk_pkg.sv
hdl/k_stacks_shared_store_top.sv
hdl/kstk_checker.sv
tb/k_stacks_shared_store_top_test.sv
